### rtl/cau_pkg.sv
// ---------------------------------------------------------------------------
// cau_pkg
// Widths, opcodes and the shared side-data type of the complex arithmetic unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package cau_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   localparam int PROD_W = 2 * WORD_BITS;
   localparam int SUM_W  = 2 * WORD_BITS + 1;
   localparam int MAG_W  = 2 * WORD_BITS;
   localparam int NUM_W  = 2 * WORD_BITS + FRAC_BITS;
   localparam int RT_W   = WORD_BITS + 2;

   localparam logic [2:0] OP_ADD  = 3'd0;
   localparam logic [2:0] OP_SUB  = 3'd1;
   localparam logic [2:0] OP_MUL  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_CONJ = 3'd4;
   localparam logic [2:0] OP_NEG  = 3'd5;
   localparam logic [2:0] OP_ABS  = 3'd6;
   localparam logic [2:0] OP_ABS2 = 3'd7;

   typedef struct packed {
      logic [2:0]       op;
      logic             neg_re;
      logic             neg_im;
      logic [MAG_W-1:0] mag_re;
      logic [MAG_W-1:0] mag_im;
      logic             dz;
      logic             qovf_re;
      logic             qovf_im;
   } side_type;

endpackage

### rtl/cau_div_pipe.sv
// ---------------------------------------------------------------------------
// cau_div_pipe
// Two-lane restoring divider, one quotient bit per stage, shared divisor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_div_pipe import cau_pkg::*; (
   input  logic                 clock,
   input  logic [MAG_W-1:0]     den,
   input  logic [MAG_W-1:0]     rem_re,
   input  logic [WORD_BITS-1:0] low_re,
   input  logic [MAG_W-1:0]     rem_im,
   input  logic [WORD_BITS-1:0] low_im,
   output logic [WORD_BITS-1:0] quot_re,
   output logic [WORD_BITS-1:0] quot_im
);

   logic [MAG_W-1:0]     den_ff  [0:WORD_BITS-1];
   logic [MAG_W-1:0]     rre_ff  [0:WORD_BITS-1];
   logic [MAG_W-1:0]     rim_ff  [0:WORD_BITS-1];
   logic [WORD_BITS-1:0] lre_ff  [0:WORD_BITS-1];
   logic [WORD_BITS-1:0] lim_ff  [0:WORD_BITS-1];
   logic [WORD_BITS-1:0] qre_ff  [0:WORD_BITS-1];
   logic [WORD_BITS-1:0] qim_ff  [0:WORD_BITS-1];

   genvar k;
   generate
      for (k = 0; k < WORD_BITS; k++) begin : g_stage
         logic [MAG_W-1:0]     d_p, rre_p, rim_p;
         logic [WORD_BITS-1:0] lre_p, lim_p, qre_p, qim_p;
         logic [MAG_W:0]       tre, tim, dre, dim;
         logic                 gre, gim;

         if (k == 0) begin : g_first
            assign d_p   = den;
            assign rre_p = rem_re;
            assign rim_p = rem_im;
            assign lre_p = low_re;
            assign lim_p = low_im;
            assign qre_p = '0;
            assign qim_p = '0;
         end else begin : g_next
            assign d_p   = den_ff[k-1];
            assign rre_p = rre_ff[k-1];
            assign rim_p = rim_ff[k-1];
            assign lre_p = lre_ff[k-1];
            assign lim_p = lim_ff[k-1];
            assign qre_p = qre_ff[k-1];
            assign qim_p = qim_ff[k-1];
         end

         always_comb begin
            tre = {rre_p, lre_p[WORD_BITS-1]};
            tim = {rim_p, lim_p[WORD_BITS-1]};
            gre = tre >= {1'b0, d_p};
            gim = tim >= {1'b0, d_p};
            dre = tre - {1'b0, d_p};
            dim = tim - {1'b0, d_p};
         end

         always_ff @(posedge clock) begin
            den_ff[k] <= d_p;
            rre_ff[k] <= gre ? dre[MAG_W-1:0] : tre[MAG_W-1:0];
            rim_ff[k] <= gim ? dim[MAG_W-1:0] : tim[MAG_W-1:0];
            lre_ff[k] <= {lre_p[WORD_BITS-2:0], 1'b0};
            lim_ff[k] <= {lim_p[WORD_BITS-2:0], 1'b0};
            qre_ff[k] <= {qre_p[WORD_BITS-2:0], gre};
            qim_ff[k] <= {qim_p[WORD_BITS-2:0], gim};
         end
      end
   endgenerate

   assign quot_re = qre_ff[WORD_BITS-1];
   assign quot_im = qim_ff[WORD_BITS-1];

endmodule

### rtl/cau_sqrt_pipe.sv
// ---------------------------------------------------------------------------
// cau_sqrt_pipe
// Restoring integer square root, one root bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_sqrt_pipe import cau_pkg::*; (
   input  logic                 clock,
   input  logic [MAG_W-1:0]     radicand,
   output logic [WORD_BITS-1:0] root
);

   logic [MAG_W-1:0]     rad_ff  [0:WORD_BITS-1];
   logic [WORD_BITS-1:0] rem_ff  [0:WORD_BITS-1];
   logic [WORD_BITS-1:0] root_ff [0:WORD_BITS-1];

   genvar k;
   generate
      for (k = 0; k < WORD_BITS; k++) begin : g_stage
         logic [MAG_W-1:0]     rad_p;
         logic [WORD_BITS-1:0] rem_p, root_p;
         logic [RT_W-1:0]      t, trial, diff;
         logic                 ge;

         if (k == 0) begin : g_first
            assign rad_p  = radicand;
            assign rem_p  = '0;
            assign root_p = '0;
         end else begin : g_next
            assign rad_p  = rad_ff[k-1];
            assign rem_p  = rem_ff[k-1];
            assign root_p = root_ff[k-1];
         end

         always_comb begin
            t     = {rem_p, rad_p[MAG_W-1 -: 2]};
            trial = {root_p, 2'b01};
            ge    = t >= trial;
            diff  = t - trial;
         end

         always_ff @(posedge clock) begin
            rad_ff[k]  <= {rad_p[MAG_W-3:0], 2'b00};
            rem_ff[k]  <= ge ? diff[WORD_BITS-1:0] : t[WORD_BITS-1:0];
            root_ff[k] <= {root_p[WORD_BITS-2:0], ge};
         end
      end
   endgenerate

   assign root = root_ff[WORD_BITS-1];

endmodule

### rtl/complex_arith_unit.sv
// ---------------------------------------------------------------------------
// complex_arith_unit
// Pipelined complex ALU in signed fixed point: add, sub, mul, div, conj,
// neg, magnitude and squared magnitude, with saturation and flags.
// ---------------------------------------------------------------------------
// pipeline: product, sum and sign/magnitude stages, then the one-bit-per-stage
// divider and square root pipelines, then a registered output stage
// throughput: one transaction per cycle, busy is always low
// reset: synchronous, clears the valid bits of every stage
`timescale 1ns / 1ps

module complex_arith_unit import cau_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [2:0]                  req_opcode,
   input  logic signed [WORD_BITS-1:0] req_a_re,
   input  logic signed [WORD_BITS-1:0] req_a_im,
   input  logic signed [WORD_BITS-1:0] req_b_re,
   input  logic signed [WORD_BITS-1:0] req_b_im,
   output logic                        rsp_strobe,
   output logic signed [WORD_BITS-1:0] rsp_res_re,
   output logic signed [WORD_BITS-1:0] rsp_res_im,
   output logic                        rsp_div_zero,
   output logic                        rsp_overflow
);

   typedef struct packed {
      logic                 ovf;
      logic [WORD_BITS-1:0] val;
   } sat_type;

   function automatic sat_type saturate(input logic neg, input logic [MAG_W-1:0] mag);
      sat_type          r;
      logic [MAG_W-1:0] lim;
      logic [MAG_W-1:0] m;
      lim = MAG_W'(1) << (WORD_BITS - 1);
      if (!neg) lim = lim - MAG_W'(1);
      m     = mag;
      r.ovf = 1'b0;
      if (mag > lim) begin
         m     = lim;
         r.ovf = 1'b1;
      end
      r.val = neg ? (~m[WORD_BITS-1:0] + 1'b1) : m[WORD_BITS-1:0];
      return r;
   endfunction

   assign busy = 1'b0;

   // stage 1: products
   logic                        v1_ff;
   logic [2:0]                  op1_ff;
   logic signed [WORD_BITS-1:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [PROD_W-1:0]    p0_ff, p1_ff, p2_ff, p3_ff, p4_ff, p5_ff;
   logic signed [WORD_BITS-1:0] sq_x, sq_y;
   logic                        is_mag;

   always_comb begin
      is_mag = (req_opcode == OP_ABS) || (req_opcode == OP_ABS2);
      sq_x   = is_mag ? req_a_re : req_b_re;
      sq_y   = is_mag ? req_a_im : req_b_im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
      op1_ff <= req_opcode;
      ar1_ff <= req_a_re;
      ai1_ff <= req_a_im;
      br1_ff <= req_b_re;
      bi1_ff <= req_b_im;
      p0_ff  <= req_a_re * req_b_re;
      p1_ff  <= req_a_im * req_b_im;
      p2_ff  <= req_a_re * req_b_im;
      p3_ff  <= req_a_im * req_b_re;
      p4_ff  <= sq_x * sq_x;
      p5_ff  <= sq_y * sq_y;
   end

   // stage 2: sums
   logic                    v2_ff;
   logic [2:0]              op2_ff;
   logic signed [SUM_W-1:0] sre_ff, sim_ff, sre_in, sim_in;
   logic [MAG_W-1:0]        den2_ff;

   always_comb begin
      case (op1_ff)
         OP_ADD: begin
            sre_in = SUM_W'(ar1_ff) + SUM_W'(br1_ff);
            sim_in = SUM_W'(ai1_ff) + SUM_W'(bi1_ff);
         end
         OP_SUB: begin
            sre_in = SUM_W'(ar1_ff) - SUM_W'(br1_ff);
            sim_in = SUM_W'(ai1_ff) - SUM_W'(bi1_ff);
         end
         OP_MUL: begin
            sre_in = SUM_W'(p0_ff) - SUM_W'(p1_ff);
            sim_in = SUM_W'(p2_ff) + SUM_W'(p3_ff);
         end
         OP_DIV: begin
            sre_in = SUM_W'(p0_ff) + SUM_W'(p1_ff);
            sim_in = SUM_W'(p3_ff) - SUM_W'(p2_ff);
         end
         OP_CONJ: begin
            sre_in = SUM_W'(ar1_ff);
            sim_in = -SUM_W'(ai1_ff);
         end
         OP_NEG: begin
            sre_in = -SUM_W'(ar1_ff);
            sim_in = -SUM_W'(ai1_ff);
         end
         default: begin
            sre_in = '0;
            sim_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      op2_ff  <= op1_ff;
      sre_ff  <= sre_in;
      sim_ff  <= sim_in;
      den2_ff <= $unsigned(p4_ff) + $unsigned(p5_ff);
   end

   // stage 3: sign and magnitude
   logic                 v3_ff;
   logic [2:0]           op3_ff;
   logic                 nre3_ff, nim3_ff;
   logic [MAG_W-1:0]     mre3_ff, mim3_ff, mre3_in, mim3_in, den3_ff;
   logic [SUM_W-1:0]     are, aim;

   always_comb begin
      are     = sre_ff[SUM_W-1] ? -sre_ff : sre_ff;
      aim     = sim_ff[SUM_W-1] ? -sim_ff : sim_ff;
      mre3_in = are[MAG_W-1:0];
      mim3_in = aim[MAG_W-1:0];
      if (op2_ff == OP_MUL) begin
         mre3_in = mre3_in >> FRAC_BITS;
         mim3_in = mim3_in >> FRAC_BITS;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
      op3_ff  <= op2_ff;
      nre3_ff <= sre_ff[SUM_W-1];
      nim3_ff <= sim_ff[SUM_W-1];
      mre3_ff <= mre3_in;
      mim3_ff <= mim3_in;
      den3_ff <= den2_ff;
   end

   // divider and root feed, side data delay line
   logic [NUM_W-1:0]     num_re, num_im;
   logic [MAG_W-1:0]     rem_re, rem_im;
   logic [WORD_BITS-1:0] quot_re, quot_im, root;
   side_type             side_in;
   side_type             side_ff [0:WORD_BITS-1];
   logic [WORD_BITS-1:0] vld_ff;

   always_comb begin
      num_re  = {mre3_ff, {FRAC_BITS{1'b0}}};
      num_im  = {mim3_ff, {FRAC_BITS{1'b0}}};
      rem_re  = MAG_W'(num_re[NUM_W-1:WORD_BITS]);
      rem_im  = MAG_W'(num_im[NUM_W-1:WORD_BITS]);
      side_in.op      = op3_ff;
      side_in.neg_re  = nre3_ff;
      side_in.neg_im  = nim3_ff;
      side_in.mag_re  = mre3_ff;
      side_in.mag_im  = mim3_ff;
      side_in.dz      = (op3_ff == OP_DIV) && (den3_ff == '0);
      side_in.qovf_re = rem_re >= den3_ff;
      side_in.qovf_im = rem_im >= den3_ff;
      if (op3_ff == OP_ABS || op3_ff == OP_ABS2) begin
         side_in.neg_re = 1'b0;
         side_in.neg_im = 1'b0;
         side_in.mag_re = den3_ff >> FRAC_BITS;
         side_in.mag_im = '0;
      end
   end

   cau_div_pipe u_div (
      .clock   (clock),
      .den     (den3_ff),
      .rem_re  (rem_re),
      .low_re  (num_re[WORD_BITS-1:0]),
      .rem_im  (rem_im),
      .low_im  (num_im[WORD_BITS-1:0]),
      .quot_re (quot_re),
      .quot_im (quot_im)
   );

   cau_sqrt_pipe u_sqrt (
      .clock    (clock),
      .radicand (den3_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[WORD_BITS-2:0], v3_ff};
      end
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= side_in;
      for (int k = 1; k < WORD_BITS; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   // output stage
   side_type         sd;
   logic [MAG_W-1:0] fre, fim;
   logic             fdz;
   sat_type          rre, rim;

   always_comb begin
      sd  = side_ff[WORD_BITS-1];
      fre = sd.mag_re;
      fim = sd.mag_im;
      fdz = 1'b0;
      case (sd.op)
         OP_DIV: begin
            if (sd.dz) begin
               fre = '0;
               fim = '0;
               fdz = 1'b1;
            end else begin
               fre = sd.qovf_re ? '1 : MAG_W'(quot_re);
               fim = sd.qovf_im ? '1 : MAG_W'(quot_im);
            end
         end
         OP_ABS: begin
            fre = MAG_W'(root);
         end
         default: begin
            fre = sd.mag_re;
         end
      endcase
      rre = saturate(sd.neg_re, fre);
      rim = saturate(sd.neg_im, fim);
   end

   logic rsp_strobe_ff;
   logic [WORD_BITS-1:0] rsp_re_ff, rsp_im_ff;
   logic rsp_dz_ff, rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= vld_ff[WORD_BITS-1];
      end
      rsp_re_ff  <= rre.val;
      rsp_im_ff  <= rim.val;
      rsp_dz_ff  <= fdz;
      rsp_ovf_ff <= rre.ovf | rim.ovf;
   end

   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_res_re   = rsp_re_ff;
   assign rsp_res_im   = rsp_im_ff;
   assign rsp_div_zero = rsp_dz_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

### test/tb_complex_arith_unit.sv
// ---------------------------------------------------------------------------
// tb_complex_arith_unit
// Self-checking testbench for the complex arithmetic unit: directed extremes
// of all eight operations and special cases, then random transactions under
// several sender idling phases, each result checked against a local model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_complex_arith_unit;
   import cau_pkg::*;

   localparam int LATENCY   = WORD_BITS + 4;
   localparam int IDLE_MAX  = 5000;
   localparam int N_RANDOM  = 250;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [127:0] big_type;

   typedef struct {
      word_type res_re;
      word_type res_im;
      logic     div_zero;
      logic     overflow;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_opcode = OP_ADD;
   word_type    req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic        rsp_strobe;
   word_type    rsp_res_re, rsp_res_im;
   logic        rsp_div_zero, rsp_overflow;

   result_type  expected_results[$];
   int          errors = 0;
   int          n_sent = 0;
   int          n_checked = 0;
   int          n_divzero = 0;
   int          n_ovf = 0;
   int          idle_pct = 0;
   int          idle_count = 0;
   logic        accepted = 1'b0;

   complex_arith_unit DUT (
      .clock, .reset, .start, .busy,
      .req_opcode, .req_a_re, .req_a_im, .req_b_re, .req_b_im,
      .rsp_strobe, .rsp_res_re, .rsp_res_im, .rsp_div_zero, .rsp_overflow
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic big_type shr_trunc(big_type x);
      if (x < 0) return -((-x) >>> FRAC_BITS);
      return x >>> FRAC_BITS;
   endfunction

   function automatic word_type saturate(big_type x, ref logic ovf);
      big_type hi, lo;
      hi = (big_type'(1) <<< (WORD_BITS - 1)) - 1;
      lo = -(big_type'(1) <<< (WORD_BITS - 1));
      if (x > hi) begin
         ovf = 1'b1;
         return word_type'(hi);
      end
      if (x < lo) begin
         ovf = 1'b1;
         return word_type'(lo);
      end
      return word_type'(x);
   endfunction

   function automatic big_type isqrt(big_type n);
      big_type rem, root, bitv;
      rem  = n;
      root = 0;
      bitv = big_type'(1) <<< 126;
      while (bitv > rem) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem  = rem - (root + bitv);
            root = (root >>> 1) + bitv;
         end else begin
            root = root >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return root;
   endfunction

   function automatic result_type predict_complex(logic [2:0] op, word_type a_re,
                                                  word_type a_im, word_type b_re,
                                                  word_type b_im);
      big_type    ar, ai, br, bi, re, im, den;
      result_type r;
      logic       ovf;
      ar = a_re;
      ai = a_im;
      br = b_re;
      bi = b_im;
      re = 0;
      im = 0;
      ovf = 1'b0;
      r.div_zero = 1'b0;
      case (op)
         OP_ADD: begin
            re = ar + br;
            im = ai + bi;
         end
         OP_SUB: begin
            re = ar - br;
            im = ai - bi;
         end
         OP_MUL: begin
            re = shr_trunc(ar * br - ai * bi);
            im = shr_trunc(ar * bi + ai * br);
         end
         OP_DIV: begin
            if (br == 0 && bi == 0) begin
               r.div_zero = 1'b1;
            end else begin
               den = br * br + bi * bi;
               re  = ((ar * br + ai * bi) <<< FRAC_BITS) / den;
               im  = ((ai * br - ar * bi) <<< FRAC_BITS) / den;
            end
         end
         OP_CONJ: begin
            re = ar;
            im = -ai;
         end
         OP_NEG: begin
            re = -ar;
            im = -ai;
         end
         OP_ABS: re = isqrt(ar * ar + ai * ai);
         default: re = shr_trunc(ar * ar + ai * ai);
      endcase
      r.res_re = saturate(re, ovf);
      r.res_im = saturate(im, ovf);
      r.overflow = ovf;
      return r;
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $error("result with no transaction outstanding: re=%0d im=%0d",
                   rsp_res_re, rsp_res_im);
            errors++;
         end else begin
            e = expected_results.pop_front();
            n_checked++;
            if (rsp_res_re !== e.res_re) begin
               $error("res_re expected %0d actual %0d", e.res_re, rsp_res_re);
               errors++;
            end
            if (rsp_res_im !== e.res_im) begin
               $error("res_im expected %0d actual %0d", e.res_im, rsp_res_im);
               errors++;
            end
            if (rsp_div_zero !== e.div_zero) begin
               $error("div_zero expected %0b actual %0b", e.div_zero, rsp_div_zero);
               errors++;
            end
            if (rsp_overflow !== e.overflow) begin
               $error("overflow expected %0b actual %0b", e.overflow, rsp_overflow);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (accepted || rsp_strobe || reset) begin
         idle_count <= 0;
      end else begin
         idle_count <= idle_count + 1;
         if (idle_count >= IDLE_MAX) begin
            $display("timeout: no transaction for %0d cycles", IDLE_MAX);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic send_item(logic [2:0] op, word_type a_re, word_type a_im,
                            word_type b_re, word_type b_im);
      result_type e;
      logic       ready;
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         accepted = 1'b0;
      end
      @(negedge clock);
      start = 1'b1;
      req_opcode = op;
      req_a_re = a_re;
      req_a_im = a_im;
      req_b_re = b_re;
      req_b_im = b_im;
      ready = !busy;
      accepted = ready;
      while (!ready) begin
         @(negedge clock);
         ready = !busy;
         accepted = ready;
      end
      e = predict_complex(op, a_re, a_im, b_re, b_im);
      expected_results.push_back(e);
      n_sent++;
      if (e.div_zero) n_divzero++;
      if (e.overflow) n_ovf++;
      @(posedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      start = 1'b0;
      accepted = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   task automatic test_operations;
      word_type mx, mn;
      mx = {1'b0, {(WORD_BITS-1){1'b1}}};
      mn = {1'b1, {(WORD_BITS-1){1'b0}}};
      for (int op = 0; op < 8; op++) begin
         send_item(3'(op), 32'sh0003_8000, -32'sh0001_4000, 32'sh0000_c000,
                   32'sh0002_0000);
         send_item(3'(op), mx, mn, mx, mn);
      end
      send_item(OP_ADD, mn, mn, -1, -1);
   endtask

   task automatic test_special_cases;
      word_type mx, mn;
      mx = {1'b0, {(WORD_BITS-1){1'b1}}};
      mn = {1'b1, {(WORD_BITS-1){1'b0}}};
      send_item(OP_CONJ, mx, mn, 0, 0);
      send_item(OP_NEG, mn, mn, 0, 0);
      send_item(OP_DIV, 32'sh0001_0000, 5, 0, 0);
      send_item(OP_DIV, mx, mx, 1, 0);
      send_item(OP_DIV, 0, 0, mn, mn);
      send_item(OP_MUL, mn, mn, mn, mn);
      send_item(OP_ABS, mn, mn, 0, 0);
      send_item(OP_ABS2, mn, mx, 0, 0);
      drain();
   endtask

   function automatic word_type rand_operand;
      case ($urandom_range(5))
         0:       return word_type'($urandom);
         1:       return word_type'($urandom_range(0, 4)) - 2;
         2:       return $urandom_range(1) ? {1'b0, {(WORD_BITS-1){1'b1}}}
                                           : {1'b1, {(WORD_BITS-1){1'b0}}};
         3:       return word_type'($signed($urandom) >>> 8);
         default: return word_type'($signed($urandom) >>> $urandom_range(4, 28));
      endcase
   endfunction

   task automatic test_random(int pct);
      word_type br, bi;
      idle_pct = pct;
      for (int i = 0; i < N_RANDOM; i++) begin
         br = rand_operand();
         bi = rand_operand();
         if ($urandom_range(15) == 0) begin
            br = 0;
            bi = 0;
         end
         send_item(3'($urandom_range(7)), rand_operand(), rand_operand(), br, bi);
      end
      drain();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_operations();
      test_special_cases();
      test_random(0);
      test_random(60);
      test_random(0);
      test_random(14);
      repeat (LATENCY + 8) @(negedge clock);
      $display("covered %0d transactions over all eight operations, %0d results checked",
               n_sent, n_checked);
      $display("%0d zero divisors, %0d saturated results, sender idling 0/60/14 in 100",
               n_divzero, n_ovf);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
         end
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
rtl/cau_pkg.sv
rtl/cau_div_pipe.sv
rtl/cau_sqrt_pipe.sv
rtl/complex_arith_unit.sv
test/tb_complex_arith_unit.sv
